/* sv/gfba_pkg.sv */
package gfba_pkg;

	localparam int BlockW = 10;
	localparam int CountW = 7;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic              action;
		logic [CountW-1:0] count;
		logic [BlockW-1:0] block;
		logic              batch_first;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic              block_valid;
		logic [BlockW-1:0] out_block;
		logic              last;
	} rsp_t;

endpackage

/* sv/grouped_free_block_allocator.sv */
// Free, rejected, empty and refused allocate items: one result, registered, in the cycle after
// start is taken, and the next item may start in that same cycle (one item a cycle).
// An allocate of n blocks: the blocks come out back to back, the first in the cycle after
// start, one stack memory read per block; busy is high while they come out.
// Reset is asynchronous and takes effect at once: there is no clearing pass. Stack
// entries below a low-water mark were never overwritten and read as their own index.
module grouped_free_block_allocator #(
	parameter int NUM_BLOCKS  = 1024,
	parameter int MAX_REQUEST = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  gfba_pkg::req_t req,
	output logic           busy,
	output logic           rsp_valid,
	output gfba_pkg::rsp_t rsp
);

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int SW = ((CW > gfba_pkg::CountW) ? CW : gfba_pkg::CountW) + 1;
	localparam int XW = (AW > gfba_pkg::BlockW) ? AW : gfba_pkg::BlockW;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_POP  = 2'b10
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               fc_q;
	logic [CW-1:0]               low_q;
	logic                        batch_acc_q;
	logic [gfba_pkg::CountW-1:0] rem_q;
	gfba_pkg::rsp_t              res_q;
	logic                        res_v_q;
	logic [AW-1:0]               addr_s1;
	logic                        unwr_s1;

	logic                        accept;
	logic                        acc_alloc_ok;
	logic                        acc_free;
	logic                        alloc_ok;
	logic [SW-1:0]               sum;
	logic                        fits;
	logic                        acc_now;
	logic                        push;
	logic                        issue;
	logic                        pop_st;
	logic [CW-1:0]               pop_addr;
	logic [gfba_pkg::BlockW-1:0] rd_data;
	logic [XW-1:0]               addr_x;

	assign pop_st   = (state_q == S_POP);
	assign busy     = pop_st;
	assign accept   = start && !busy;
	assign pop_addr = fc_q - CW'(1);

	assign alloc_ok = (req.count != '0)
		&& (req.count <= gfba_pkg::CountW'(MAX_REQUEST))
		&& (SW'(req.count) <= SW'(fc_q));
	assign acc_alloc_ok = accept && (req.action == gfba_pkg::ACT_ALLOC) && alloc_ok;
	assign acc_free     = accept && (req.action == gfba_pkg::ACT_FREE);

	assign sum     = SW'(fc_q) + SW'(req.count);
	assign fits    = (sum <= SW'(NUM_BLOCKS));
	assign acc_now = req.batch_first ? fits : batch_acc_q;
	assign push    = acc_now && (fc_q != CW'(NUM_BLOCKS));

	// A read goes out when an allocate starts and for every further block of it.
	assign issue = acc_alloc_ok || (pop_st && (rem_q != gfba_pkg::CountW'(1)));

	gfba_ram #(
		.WIDTH(gfba_pkg::BlockW),
		.DEPTH(NUM_BLOCKS)
	) u_stack (
		.clk  (clk),
		.we   (acc_free && push),
		.waddr(fc_q[AW-1:0]),
		.wdata(req.block),
		.re   (issue),
		.raddr(pop_addr[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fc_q        <= CW'(NUM_BLOCKS);
			low_q       <= CW'(NUM_BLOCKS);
			batch_acc_q <= 1'b0;
			rem_q       <= '0;
			res_v_q     <= 1'b0;
		end else begin
			res_v_q <= accept && !acc_alloc_ok;
			if (acc_free && req.batch_first) begin
				batch_acc_q <= fits;
			end
			if (acc_free && push) begin
				fc_q <= fc_q + CW'(1);
			end
			if (issue) begin
				fc_q <= pop_addr;
				if (pop_addr < low_q) begin
					low_q <= pop_addr;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (acc_alloc_ok) begin
						state_q <= S_POP;
						rem_q   <= req.count;
					end
				end
				S_POP: begin
					rem_q <= rem_q - gfba_pkg::CountW'(1);
					if (rem_q == gfba_pkg::CountW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= pop_addr[AW-1:0];
			unwr_s1 <= (pop_addr < low_q);
		end
		res_q.block_valid <= 1'b0;
		res_q.out_block   <= '0;
		res_q.last        <= 1'b1;
		if (req.action == gfba_pkg::ACT_FREE) begin
			res_q.status <= push ? gfba_pkg::STAT_OK : gfba_pkg::STAT_FULL;
		end else if (req.count == '0) begin
			res_q.status <= gfba_pkg::STAT_OK;
		end else begin
			res_q.status <= gfba_pkg::STAT_SHORT;
		end
	end

	assign addr_x = XW'(addr_s1);

	always_comb begin
		rsp_valid = pop_st || res_v_q;
		rsp       = res_q;
		if (pop_st) begin
			rsp.status      = gfba_pkg::STAT_OK;
			rsp.block_valid = 1'b1;
			rsp.out_block   = unwr_s1 ? addr_x[gfba_pkg::BlockW-1:0] : rd_data;
			rsp.last        = (rem_q == gfba_pkg::CountW'(1));
		end
	end

endmodule

/* sv/gfba_ram.sv */
module gfba_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/gfba_checker.sv */
module gfba_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input gfba_pkg::req_t req,
	input logic           busy,
	input logic           rsp_valid,
	input gfba_pkg::rsp_t rsp
);

	// Every accepted beat is answered in the very next cycle.
	a_answer_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> rsp_valid)
		else $error("accepted item got no result in the next cycle");

	// A result without a block closes its item.
	a_noblk_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.block_valid |-> rsp.last)
		else $error("result without block is not last");

	// Error results never carry a block.
	a_err_noblk: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != gfba_pkg::STAT_OK) |-> !rsp.block_valid)
		else $error("error result carries a block");

	// Blocks of one allocate come out back to back while busy holds inputs off.
	a_pop_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.block_valid && !rsp.last
			|-> busy ##1 (rsp_valid && rsp.block_valid))
		else $error("allocate block run broken");

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (.*);

/* test/tb_grouped_free_block_allocator.sv */
module tb_grouped_free_block_allocator;

	localparam int NUM_BLK  = 1024;
	localparam int MAX_REQ  = 64;
	localparam int RAND_ITEMS = 200;

	typedef struct {
		gfba_pkg::req_t req;
		bit             typed;
		gfba_pkg::rsp_t want;
	} dir_row_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	gfba_pkg::req_t req;
	logic           busy;
	logic           rsp_valid;
	gfba_pkg::rsp_t rsp;

	// Predicted state of the free stack.
	logic [gfba_pkg::BlockW-1:0] stack_img [0:NUM_BLK-1];
	int                          stack_fill;
	bit                          batch_ok;

	gfba_pkg::rsp_t awaited_rsp [$];
	dir_row_t       dir_tab [$];
	int             fail_cnt;
	int             idle_pct;

	grouped_free_block_allocator #(
		.NUM_BLOCKS (NUM_BLK),
		.MAX_REQUEST(MAX_REQ)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	always #2 clk = ~clk;

	function automatic dir_row_t dir_row(logic act, int cnt, int blk, logic first, bit typed,
			gfba_pkg::status_t st, logic bv, int ob);
		dir_row_t row;
		row.req.action      = act;
		row.req.count       = cnt[gfba_pkg::CountW-1:0];
		row.req.block       = blk[gfba_pkg::BlockW-1:0];
		row.req.batch_first = first;
		row.typed           = typed;
		row.want.status      = st;
		row.want.block_valid = bv;
		row.want.out_block   = ob[gfba_pkg::BlockW-1:0];
		row.want.last        = 1'b1;
		return row;
	endfunction

	task automatic tab_row(logic act, int cnt, int blk, logic first, bit typed,
			gfba_pkg::status_t st, logic bv, int ob);
		dir_tab.insert(dir_tab.size(), dir_row(act, cnt, blk, first, typed, st, bv, ob));
	endtask

	function automatic logic [gfba_pkg::CountW-1:0] rand_count(int lo, int hi);
		int v;
		v = $urandom_range(lo, hi);
		return v[gfba_pkg::CountW-1:0];
	endfunction

	function automatic logic [gfba_pkg::BlockW-1:0] rand_block();
		int v;
		v = $urandom_range(0, NUM_BLK - 1);
		return v[gfba_pkg::BlockW-1:0];
	endfunction

	task automatic expect_rsp(input gfba_pkg::rsp_t res);
		awaited_rsp.insert(awaited_rsp.size(), res);
	endtask

	// Updates the predicted stack for one accepted item and queues the results it causes.
	task automatic track_free_stack(input gfba_pkg::req_t r);
		gfba_pkg::rsp_t res;
		int             k;
		res = '0;
		res.last = 1'b1;
		if (r.action == gfba_pkg::ACT_ALLOC) begin
			if (r.count == 0) begin
				res.status = gfba_pkg::STAT_OK;
				expect_rsp(res);
			end else if (r.count > MAX_REQ || r.count > stack_fill) begin
				res.status = gfba_pkg::STAT_SHORT;
				expect_rsp(res);
			end else begin
				for (k = 0; k < r.count; k++) begin
					stack_fill--;
					res.status      = gfba_pkg::STAT_OK;
					res.block_valid = 1'b1;
					res.out_block   = stack_img[stack_fill];
					res.last        = (k == r.count - 1);
					expect_rsp(res);
				end
			end
		end else begin
			if (r.batch_first)
				batch_ok = (stack_fill + r.count <= NUM_BLK);
			if (batch_ok && stack_fill < NUM_BLK) begin
				stack_img[stack_fill] = r.block;
				stack_fill++;
				res.status = gfba_pkg::STAT_OK;
			end else begin
				res.status = gfba_pkg::STAT_FULL;
			end
			expect_rsp(res);
		end
	endtask

	task automatic send_item(input gfba_pkg::req_t r, input bit typed,
			input gfba_pkg::rsp_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		track_free_stack(r);
		// A typed row causes exactly one result; the typed value replaces the predicted one.
		if (typed)
			awaited_rsp[awaited_rsp.size() - 1] = want;
	endtask

	// Every result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		gfba_pkg::rsp_t exp_r;
		if (arst_n && rsp_valid) begin
			if (awaited_rsp.size() == 0) begin
				$error("unexpected result: status %0d block_valid %0d out_block %0d last %0d",
					rsp.status, rsp.block_valid, rsp.out_block, rsp.last);
				fail_cnt++;
			end else begin
				exp_r = awaited_rsp.pop_front();
				if (rsp.status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, rsp.status);
					fail_cnt++;
				end
				if (rsp.block_valid !== exp_r.block_valid) begin
					$error("block_valid: expected %0d, actual %0d",
						exp_r.block_valid, rsp.block_valid);
					fail_cnt++;
				end
				if (rsp.out_block !== exp_r.out_block) begin
					$error("out_block: expected %0d, actual %0d", exp_r.out_block, rsp.out_block);
					fail_cnt++;
				end
				if (rsp.last !== exp_r.last) begin
					$error("last: expected %0d, actual %0d", exp_r.last, rsp.last);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		gfba_pkg::req_t r;
		gfba_pkg::rsp_t none;
		int             i;
		int             j;
		int             n;
		int             announce;
		int             sel;
		int             rand_sent;

		clk      = 1'b0;
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		fail_cnt = 0;
		none     = '0;
		for (i = 0; i < NUM_BLK; i++)
			stack_img[i] = i[gfba_pkg::BlockW-1:0];
		stack_fill = NUM_BLK;
		batch_ok   = 1'b0;

		// Directed part: the stack starts full with block 1023 on top.
		// A continuation before any batch, then an empty batch that finds the stack full.
		tab_row(gfba_pkg::ACT_FREE, 0, 'h155, 1'b0, 1, gfba_pkg::STAT_FULL, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 0, 'h2AA, 1'b1, 1, gfba_pkg::STAT_FULL, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 5, 'h3FF, 1'b0, 1, gfba_pkg::STAT_FULL, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 1, 0, 1'b1, 1, gfba_pkg::STAT_FULL, 1'b0, 0);
		tab_row(gfba_pkg::ACT_ALLOC, 0, 0, 1'b0, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_ALLOC, 65, 0, 1'b0, 1, gfba_pkg::STAT_SHORT, 1'b0, 0);
		tab_row(gfba_pkg::ACT_ALLOC, 127, 'h3FF, 1'b1, 1, gfba_pkg::STAT_SHORT, 1'b0, 0);
		tab_row(gfba_pkg::ACT_ALLOC, 1, 0, 1'b0, 1, gfba_pkg::STAT_OK, 1'b1, 1023);
		tab_row(gfba_pkg::ACT_ALLOC, 64, 'h2AA, 1'b0, 0, gfba_pkg::STAT_OK, 1'b0, 0);
		// With 959 free, a batch of 66 is one too many and one of 65 refills the store.
		tab_row(gfba_pkg::ACT_FREE, 66, 0, 1'b1, 1, gfba_pkg::STAT_FULL, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 0, 'h3FF, 1'b0, 1, gfba_pkg::STAT_FULL, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 65, 'h3FF, 1'b1, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		// Block 1 is still on the stack, so this is a duplicate free.
		tab_row(gfba_pkg::ACT_FREE, 0, 1, 1'b0, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 0, 'h155, 1'b0, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 0, 'h2AA, 1'b0, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_ALLOC, 4, 0, 1'b1, 0, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 3, 7, 1'b1, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 0, 8, 1'b0, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_ALLOC, 2, 0, 1'b0, 0, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_ALLOC, 64, 0, 1'b0, 0, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 127, 'h1FF, 1'b1, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_FREE, 64, 'h200, 1'b0, 1, gfba_pkg::STAT_OK, 1'b0, 0);
		tab_row(gfba_pkg::ACT_ALLOC, 3, 'h3FF, 1'b1, 0, gfba_pkg::STAT_OK, 1'b0, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 23;
		foreach (dir_tab[i])
			send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

		// Random part: mostly allocations and well-formed free batches, some noise.
		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			if (rand_sent < RAND_ITEMS / 3)
				idle_pct = 23;
			else if (rand_sent < 2 * RAND_ITEMS / 3)
				idle_pct = 69;
			else
				idle_pct = 0;
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				r.action      = gfba_pkg::ACT_ALLOC;
				r.block       = rand_block();
				r.batch_first = ($urandom_range(0, 1) == 1);
				sel = $urandom_range(0, 99);
				if (sel < 10 && stack_fill > 0 && stack_fill <= MAX_REQ)
					r.count = stack_fill[gfba_pkg::CountW-1:0];
				else if (sel < 15)
					r.count = '0;
				else if (sel < 22)
					r.count = rand_count(MAX_REQ + 1, 127);
				else if (sel < 50)
					r.count = rand_count(1, 8);
				else
					r.count = rand_count(1, MAX_REQ);
				send_item(r, 1'b0, none);
				rand_sent++;
			end else if (sel < 93) begin
				n = $urandom_range(1, 6);
				sel = $urandom_range(0, 99);
				if (sel < 15)
					announce = $urandom_range(n, 127);
				else if (sel < 25)
					announce = n - 1;
				else
					announce = n;
				for (j = 0; j < n; j++) begin
					r.action      = gfba_pkg::ACT_FREE;
					r.batch_first = (j == 0);
					r.count       = (j == 0) ? announce[gfba_pkg::CountW-1:0]
						: rand_count(0, 127);
					r.block       = rand_block();
					send_item(r, 1'b0, none);
					rand_sent++;
				end
			end else begin
				r.action      = gfba_pkg::ACT_FREE;
				r.batch_first = 1'b0;
				r.count       = rand_count(0, 127);
				r.block       = rand_block();
				send_item(r, 1'b0, none);
				rand_sent++;
			end
		end
		start <= 1'b0;

		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
